FILE: sv/hcs_pkg.sv
`default_nettype none
package hcs_pkg;

  localparam int Axes   = 6;
  localparam int GangW  = 6;
  localparam int MotW   = 2 * GangW;
  localparam int PhaseW = 5;
  localparam int LocW   = 3;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [GangW-1:0] AxisLimit =
    (Axes >= GangW) ? {GangW{1'b1}} : GangW'((32'd1 << Axes) - 32'd1);
  localparam logic [MotW-1:0] GangLo = {{GangW{1'b0}}, {GangW{1'b1}}};
  localparam logic [MotW-1:0] GangHi = {{GangW{1'b1}}, {GangW{1'b0}}};
  localparam logic [PhaseW-1:0] SquaredPhases = 5'd6;

  typedef enum logic {
    OpStart = 1'b0,
    OpTick  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    AlarmNone     = 3'd0,
    AlarmReset    = 3'd1,
    AlarmDoor     = 3'd2,
    AlarmApproach = 3'd3,
    AlarmPulloff  = 3'd4
  } alarm_e;

  typedef enum logic [2:0] {
    RegHomingAxes   = 3'd0,
    RegGang0Motors  = 3'd1,
    RegGang1Motors  = 3'd2,
    RegSharedEnd    = 3'd3,
    RegGang0End     = 3'd4,
    RegGang1End     = 3'd5,
    RegLocateCycles = 3'd6
  } reg_e;

  typedef struct packed {
    logic [GangW-1:0] homing_axes;
    logic [GangW-1:0] gang0_motors;
    logic [GangW-1:0] gang1_motors;
    logic [GangW-1:0] shared_endstop;
    logic [GangW-1:0] gang0_endstop;
    logic [GangW-1:0] gang1_endstop;
    logic [LocW-1:0]  locate_cycles;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [GangW-1:0] axis_mask;
    logic [MotW-1:0]  limit_mask;
    logic             reset_req;
    logic             door_open;
    logic             cycle_stop;
  } item_t;

  typedef struct packed {
    logic             move_start;
    logic             move_approach;
    logic             move_seek;
    logic [MotW-1:0]  move_motors;
    logic [MotW-1:0]  lock_mask;
    logic             busy_res;
    logic             done_res;
    logic [2:0]       alarm;
    logic [GangW-1:0] homed_axes;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [PhaseW-1:0] idx;
  } next_t;

  function automatic logic [MotW-1:0] phase_set(input logic [PhaseW-1:0] idx,
                                                 input logic sq,
                                                 input logic [MotW-1:0] mask);
    logic [MotW-1:0] r;
    if (!sq || idx < 5'd2) r = mask;
    else if (idx < 5'd4) r = mask & GangLo;
    else r = mask & GangHi;
    return r;
  endfunction

  // first phase at or after idx with motors to move
  function automatic next_t next_phase(input logic [PhaseW-1:0] idx,
                                       input logic sq,
                                       input logic [MotW-1:0] mask,
                                       input logic [LocW-1:0] loc);
    next_t r;
    logic [PhaseW-1:0] n;
    n = 5'd2 + {1'b0, loc, 1'b0};
    r.found = 1'b0;
    r.idx = idx;
    if (!sq) begin
      r.found = (idx < n) && (mask != '0);
    end else begin
      for (int j = 0; j < int'(SquaredPhases); j++) begin
        if (!r.found && (PhaseW'(j) >= idx) &&
            (phase_set(PhaseW'(j), 1'b1, mask) != '0)) begin
          r.found = 1'b1;
          r.idx = PhaseW'(j);
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/hcs_cfg_regs.sv
`default_nettype none
module hcs_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hcs_pkg::AddrW-1:0]  paddr,
  input  wire logic [hcs_pkg::DataW-1:0]  pwdata,
  output logic      [hcs_pkg::DataW-1:0]  prdata,
  output logic                            pready,
  output hcs_pkg::cfg_t                   cfg_o
);

  hcs_pkg::cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.homing_axes    <= 6'h3F;
      cfg_q.gang0_motors   <= 6'h3F;
      cfg_q.gang1_motors   <= 6'h00;
      cfg_q.shared_endstop <= 6'h00;
      cfg_q.gang0_endstop  <= 6'h3F;
      cfg_q.gang1_endstop  <= 6'h00;
      cfg_q.locate_cycles  <= 3'd1;
    end else if (wr_en) begin
      case (reg_idx)
        hcs_pkg::RegHomingAxes:   cfg_q.homing_axes    <= pwdata[5:0];
        hcs_pkg::RegGang0Motors:  cfg_q.gang0_motors   <= pwdata[5:0];
        hcs_pkg::RegGang1Motors:  cfg_q.gang1_motors   <= pwdata[5:0];
        hcs_pkg::RegSharedEnd:    cfg_q.shared_endstop <= pwdata[5:0];
        hcs_pkg::RegGang0End:     cfg_q.gang0_endstop  <= pwdata[5:0];
        hcs_pkg::RegGang1End:     cfg_q.gang1_endstop  <= pwdata[5:0];
        hcs_pkg::RegLocateCycles: cfg_q.locate_cycles  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hcs_pkg::RegHomingAxes:   prdata = 32'(cfg_q.homing_axes);
      hcs_pkg::RegGang0Motors:  prdata = 32'(cfg_q.gang0_motors);
      hcs_pkg::RegGang1Motors:  prdata = 32'(cfg_q.gang1_motors);
      hcs_pkg::RegSharedEnd:    prdata = 32'(cfg_q.shared_endstop);
      hcs_pkg::RegGang0End:     prdata = 32'(cfg_q.gang0_endstop);
      hcs_pkg::RegGang1End:     prdata = 32'(cfg_q.gang1_endstop);
      hcs_pkg::RegLocateCycles: prdata = 32'(cfg_q.locate_cycles);
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hcs_seq.sv
`default_nettype none
module hcs_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  hcs_pkg::item_t     item_i,
  input  hcs_pkg::cfg_t      cfg_i,
  output hcs_pkg::res_t      res_o
);

  logic                             active_q, active_d;
  logic [hcs_pkg::PhaseW-1:0]       phase_q, phase_d;
  logic [hcs_pkg::GangW-1:0]        cycle_axes_q, cycle_axes_d;
  logic [hcs_pkg::MotW-1:0]         motor_q, motor_d;
  logic                             squared_q, squared_d;
  logic [hcs_pkg::MotW-1:0]         remaining_q, remaining_d;
  logic [hcs_pkg::MotW-1:0]         locked_q, locked_d;

  always_comb begin
    logic [hcs_pkg::GangW-1:0] ax, g0, g1;
    logic [hcs_pkg::MotW-1:0]  mask, rem, lck, set;
    logic                      sqd, appr, end_phase;
    hcs_pkg::next_t            np;
    hcs_pkg::alarm_e           alm;

    active_d     = active_q;
    phase_d      = phase_q;
    cycle_axes_d = cycle_axes_q;
    motor_d      = motor_q;
    squared_d    = squared_q;
    remaining_d  = remaining_q;
    locked_d     = locked_q;
    res_o        = '0;
    alm          = hcs_pkg::AlarmNone;
    end_phase    = 1'b0;
    ax = '0; g0 = '0; g1 = '0; mask = '0; sqd = 1'b0; set = '0;
    rem = remaining_q;
    lck = locked_q;
    appr = ~phase_q[0];
    np = '0;

    if (item_i.operation == hcs_pkg::OpStart) begin
      if (!active_q) begin
        ax   = item_i.axis_mask & cfg_i.homing_axes & hcs_pkg::AxisLimit;
        g0   = ax & cfg_i.gang0_motors;
        g1   = ax & cfg_i.gang1_motors;
        mask = {g1, g0};
        sqd  = |(g0 & g1 & (cfg_i.shared_endstop | ~cfg_i.gang0_endstop |
                            ~cfg_i.gang1_endstop));
        np   = hcs_pkg::next_phase('0, sqd, mask, cfg_i.locate_cycles);
        cycle_axes_d = ax;
        motor_d      = mask;
        squared_d    = sqd;
        if (!np.found) begin
          res_o.done_res   = 1'b1;
          res_o.homed_axes = ax;
          phase_d          = '0;
        end else begin
          set              = hcs_pkg::phase_set(np.idx, sqd, mask);
          active_d         = 1'b1;
          res_o.move_start = 1'b1;
          phase_d          = np.idx;
          remaining_d      = set;
          locked_d         = ~set;
        end
      end
    end else if (active_q) begin
      // lock motors that reach their switch during an approach
      if (appr) begin
        lck = lck | item_i.limit_mask;
        rem = rem & ~item_i.limit_mask;
      end
      if (item_i.reset_req) alm = hcs_pkg::AlarmReset;
      else if (item_i.door_open) alm = hcs_pkg::AlarmDoor;
      else if (item_i.cycle_stop) begin
        if (appr) alm = hcs_pkg::AlarmApproach;
        else if ((item_i.limit_mask & rem) != '0) alm = hcs_pkg::AlarmPulloff;
        else rem = '0;
      end
      if (alm != hcs_pkg::AlarmNone) begin
        active_d = 1'b0;
        phase_d  = '0;
        rem      = '0;
      end else if (rem == '0) begin
        end_phase = 1'b1;
      end
      if (end_phase) begin
        np = hcs_pkg::next_phase(phase_q + 5'd1, squared_q, motor_q,
                                 cfg_i.locate_cycles);
        if (!np.found) begin
          active_d         = 1'b0;
          phase_d          = '0;
          res_o.done_res   = 1'b1;
          res_o.homed_axes = cycle_axes_q;
        end else begin
          set              = hcs_pkg::phase_set(np.idx, squared_q, motor_q);
          res_o.move_start = 1'b1;
          phase_d          = np.idx;
          rem              = set;
          lck              = ~set;
        end
      end
      remaining_d = rem;
      locked_d    = lck;
    end

    res_o.alarm         = alm;
    res_o.move_approach = active_d & ~phase_d[0];
    res_o.move_seek     = active_d & (phase_d == '0);
    res_o.move_motors   = active_d ? hcs_pkg::phase_set(phase_d, squared_d, motor_d) : '0;
    res_o.lock_mask     = locked_d;
    res_o.busy_res      = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      phase_q      <= '0;
      cycle_axes_q <= '0;
      motor_q      <= '0;
      squared_q    <= 1'b0;
      remaining_q  <= '0;
      locked_q     <= '1;
    end else if (fire_i) begin
      active_q     <= active_d;
      phase_q      <= phase_d;
      cycle_axes_q <= cycle_axes_d;
      motor_q      <= motor_d;
      squared_q    <= squared_d;
      remaining_q  <= remaining_d;
      locked_q     <= locked_d;
    end
  end

  a_idle_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (phase_q == '0))
    else $error("phase index not zero while idle");

  a_active_has_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (remaining_q != '0))
    else $error("active move with no remaining motors");

  a_locked_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remaining_q & locked_q) == '0)
    else $error("a remaining motor is also locked");

endmodule
`default_nettype wire

FILE: sv/homing_cycle_sequencer_unit.sv
// Throughput: one item per cycle unless the output stalls; the sequencer state updates
// as an item moves from the input register through one level of mask logic into the
// result register. A stalled result holds while one more item waits in the input
// register. Reset (rst_ni low, asynchronous) empties both registers, sets the cycle idle
// with all motors locked, and loads the register reset values.
`default_nettype none
module homing_cycle_sequencer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       operation_i,
  input  wire logic [5:0]                 axis_mask_i,
  input  wire logic [11:0]                limit_mask_i,
  input  wire logic                       reset_req_i,
  input  wire logic                       door_open_i,
  input  wire logic                       cycle_stop_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            move_start_o,
  output logic                            move_approach_o,
  output logic                            move_seek_o,
  output logic [11:0]                     move_motors_o,
  output logic [11:0]                     lock_mask_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [2:0]                      alarm_o,
  output logic [5:0]                      homed_axes_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hcs_pkg::AddrW-1:0]  paddr,
  input  wire logic [hcs_pkg::DataW-1:0]  pwdata,
  output logic      [hcs_pkg::DataW-1:0]  prdata,
  output logic                            pready
);

  hcs_pkg::cfg_t  cfg;
  hcs_pkg::item_t item_q;
  hcs_pkg::res_t  res_d, res_q;
  logic in_valid_q, out_valid_q, out_adv, fire;

  assign out_adv    = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & out_adv;
  assign in_stall_o = in_valid_q & ~out_adv;

  hcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hcs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.operation  <= operation_i;
      item_q.axis_mask  <= axis_mask_i;
      item_q.limit_mask <= limit_mask_i;
      item_q.reset_req  <= reset_req_i;
      item_q.door_open  <= door_open_i;
      item_q.cycle_stop <= cycle_stop_i;
    end
    if (fire) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign move_start_o    = res_q.move_start;
  assign move_approach_o = res_q.move_approach;
  assign move_seek_o     = res_q.move_seek;
  assign move_motors_o   = res_q.move_motors;
  assign lock_mask_o     = res_q.lock_mask;
  assign busy_res_o      = res_q.busy_res;
  assign done_res_o      = res_q.done_res;
  assign alarm_o         = res_q.alarm;
  assign homed_axes_o    = res_q.homed_axes;

endmodule
`default_nettype wire

FILE: tb/sv/tb_homing_cycle_sequencer_unit.sv
`default_nettype none
module tb_homing_cycle_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 100;
  localparam int RandomPhases = 10;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  hcs_pkg::item_t cur_item = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hcs_pkg::AddrW-1:0] paddr = '0;
  logic [hcs_pkg::DataW-1:0] pwdata = '0;

  logic in_stall_o, out_valid_o;
  logic move_start_o, move_approach_o, move_seek_o, busy_res_o, done_res_o;
  logic [11:0] move_motors_o, lock_mask_o;
  logic [2:0] alarm_o;
  logic [5:0] homed_axes_o;
  logic [hcs_pkg::DataW-1:0] prdata;
  logic pready;

  homing_cycle_sequencer_unit dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .operation_i(cur_item.operation),
    .axis_mask_i(cur_item.axis_mask),
    .limit_mask_i(cur_item.limit_mask),
    .reset_req_i(cur_item.reset_req),
    .door_open_i(cur_item.door_open),
    .cycle_stop_i(cur_item.cycle_stop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .move_start_o(move_start_o),
    .move_approach_o(move_approach_o),
    .move_seek_o(move_seek_o),
    .move_motors_o(move_motors_o),
    .lock_mask_o(lock_mask_o),
    .busy_res_o(busy_res_o),
    .done_res_o(done_res_o),
    .alarm_o(alarm_o),
    .homed_axes_o(homed_axes_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2ns clk = ~clk;

  // register copy and sequencer state as seen by the predictor
  hcs_pkg::cfg_t cfg = '{homing_axes: 6'h3F, gang0_motors: 6'h3F, gang1_motors: 6'h00,
                         shared_endstop: 6'h00, gang0_endstop: 6'h3F,
                         gang1_endstop: 6'h00, locate_cycles: 3'd1};
  logic hc_active = 1'b0;
  logic [hcs_pkg::PhaseW-1:0] hc_phase = '0;
  logic [5:0] hc_axes = '0;
  logic [11:0] hc_motors = '0;
  logic hc_squared = 1'b0;
  logic [11:0] hc_left = '0;
  logic [11:0] hc_locked = 12'hFFF;

  hcs_pkg::item_t queued_items[$];
  hcs_pkg::res_t due_results[$];
  logic in_fire = 1'b0;
  int errors = 0;
  int queued = 0;
  int accepted = 0;
  int results_seen = 0;
  int moves_seen = 0;
  int done_seen = 0;
  int alarm_tally[8];
  int cycle_count = 0;

  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  function automatic logic [11:0] moving_set(int idx, logic sq, logic [11:0] mm);
    if (!sq || idx < 2) return mm;
    if (idx < 4) return mm & hcs_pkg::GangLo;
    return mm & hcs_pkg::GangHi;
  endfunction

  function automatic int phase_total(logic sq, logic [2:0] loc);
    return sq ? 6 : 2 + 2 * int'(loc);
  endfunction

  // skip phases with no motor to move
  function automatic int live_phase(int idx, logic sq, logic [11:0] mm, logic [2:0] loc);
    while (idx < phase_total(sq, loc) && moving_set(idx, sq, mm) == '0) idx++;
    return idx;
  endfunction

  function automatic void launch_masks(input logic [5:0] req, output logic [5:0] ax,
                                       output logic [11:0] mm, output logic sq);
    logic [5:0] g0, g1;
    ax = req & cfg.homing_axes & hcs_pkg::AxisLimit;
    g0 = ax & cfg.gang0_motors;
    g1 = ax & cfg.gang1_motors;
    mm = {g1, g0};
    sq = |(g0 & g1 & (cfg.shared_endstop | ~cfg.gang0_endstop | ~cfg.gang1_endstop));
  endfunction

  function automatic void enter_phase(int idx);
    hc_phase = hcs_pkg::PhaseW'(idx);
    hc_left = moving_set(idx, hc_squared, hc_motors);
    hc_locked = ~hc_left;
  endfunction

  function automatic hcs_pkg::res_t next_homing_result(hcs_pkg::item_t it);
    hcs_pkg::res_t r;
    logic appr;
    int nxt;
    r = '0;
    if (it.operation == hcs_pkg::OpStart) begin
      if (!hc_active) begin
        launch_masks(it.axis_mask, hc_axes, hc_motors, hc_squared);
        nxt = live_phase(0, hc_squared, hc_motors, cfg.locate_cycles);
        if (nxt >= phase_total(hc_squared, cfg.locate_cycles)) begin
          r.done_res = 1'b1;
          r.homed_axes = hc_axes;
          hc_phase = '0;
        end else begin
          hc_active = 1'b1;
          r.move_start = 1'b1;
          enter_phase(nxt);
        end
      end
    end else if (hc_active) begin
      appr = ~hc_phase[0];
      // locking comes before any event
      if (appr) begin
        hc_locked = hc_locked | it.limit_mask;
        hc_left = hc_left & ~it.limit_mask;
      end
      if (it.reset_req) r.alarm = hcs_pkg::AlarmReset;
      else if (it.door_open) r.alarm = hcs_pkg::AlarmDoor;
      else if (it.cycle_stop) begin
        if (appr) r.alarm = hcs_pkg::AlarmApproach;
        else if ((it.limit_mask & hc_left) != '0) r.alarm = hcs_pkg::AlarmPulloff;
        else hc_left = '0;
      end
      if (r.alarm != hcs_pkg::AlarmNone) begin
        hc_active = 1'b0;
        hc_phase = '0;
        hc_left = '0;
      end else if (hc_left == '0) begin
        nxt = live_phase(int'(hc_phase) + 1, hc_squared, hc_motors, cfg.locate_cycles);
        if (nxt >= phase_total(hc_squared, cfg.locate_cycles)) begin
          hc_active = 1'b0;
          hc_phase = '0;
          r.done_res = 1'b1;
          r.homed_axes = hc_axes;
        end else begin
          r.move_start = 1'b1;
          enter_phase(nxt);
        end
      end
    end
    r.move_approach = hc_active & ~hc_phase[0];
    r.move_seek = hc_active && hc_phase == '0;
    r.move_motors = hc_active ? moving_set(int'(hc_phase), hc_squared, hc_motors) : '0;
    r.lock_mask = hc_locked;
    r.busy_res = hc_active;
    return r;
  endfunction

  function automatic void match_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // output check and input prediction
  always @(posedge clk) begin
    hcs_pkg::res_t w;
    hcs_pkg::item_t it;
    if (rst_ni) begin
      in_fire <= in_valid && !in_stall_o;
      if (out_valid_o && !out_stall) begin
        results_seen++;
        moves_seen += move_start_o;
        done_seen += done_res_o;
        alarm_tally[alarm_o]++;
        if (due_results.size() == 0) begin
          $error("result with no item waiting for it");
          errors++;
        end else begin
          w = due_results.pop_front();
          match_field("move_start", w.move_start, move_start_o);
          match_field("move_approach", w.move_approach, move_approach_o);
          match_field("move_seek", w.move_seek, move_seek_o);
          match_field("move_motors", w.move_motors, move_motors_o);
          match_field("lock_mask", w.lock_mask, lock_mask_o);
          match_field("busy_res", w.busy_res, busy_res_o);
          match_field("done_res", w.done_res, done_res_o);
          match_field("alarm", w.alarm, alarm_o);
          match_field("homed_axes", w.homed_axes, homed_axes_o);
        end
      end
      if (in_valid && !in_stall_o) begin
        it = cur_item;
        due_results.push_back(next_homing_result(it));
        accepted++;
      end
    end
  end

  // sender: bursts of items with random gaps, hold an item until taken
  always @(negedge clk) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (gap_left > 0 || queued_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur_item <= queued_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern in modes, plus one long hold-off while items keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen > 100 && queued_items.size() > 40) begin
      hold_done = 1'b1;
      hold_left = 200;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic queue_item(hcs_pkg::op_e op, logic [5:0] ax, logic [11:0] lim, logic rq,
                            logic dr, logic st);
    hcs_pkg::item_t it;
    it.operation = op;
    it.axis_mask = ax;
    it.limit_mask = lim;
    it.reset_req = rq;
    it.door_open = dr;
    it.cycle_stop = st;
    queued_items.push_back(it);
    queued++;
  endtask

  task automatic resync_tick();
    queue_item(hcs_pkg::OpTick, 6'($urandom), 12'($urandom), 1'b1, 1'($urandom),
               1'($urandom));
  endtask

  // one homing cycle walked phase by phase; a flawed one breaks at a random phase
  task automatic plan_cycle(logic [5:0] axes, logic flawed);
    logic [5:0] ax;
    logic [11:0] mm, set, left, hit;
    logic sq;
    int total, fail_at, idx;
    launch_masks(axes, ax, mm, sq);
    total = phase_total(sq, cfg.locate_cycles);
    fail_at = flawed ? $urandom_range(0, total - 1) : -1;
    queue_item(hcs_pkg::OpStart, axes, 12'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom));
    for (idx = live_phase(0, sq, mm, cfg.locate_cycles); idx < total;
         idx = live_phase(idx + 1, sq, mm, cfg.locate_cycles)) begin
      set = moving_set(idx, sq, mm);
      if ($urandom_range(0, 15) == 0)
        queue_item(hcs_pkg::OpStart, 6'($urandom), 12'($urandom), 1'($urandom),
                   1'($urandom), 1'b0);
      if (idx == fail_at) begin
        case ($urandom_range(0, 2))
          0: queue_item(hcs_pkg::OpTick, 6'($urandom), 12'($urandom), 1'b1, 1'($urandom),
                        1'($urandom));
          1: queue_item(hcs_pkg::OpTick, 6'($urandom), 12'($urandom), 1'b0, 1'b1,
                        1'($urandom));
          default: queue_item(hcs_pkg::OpTick, 6'($urandom),
                              12'($urandom) | (set & (~set + 12'd1)), 1'b0, 1'b0, 1'b1);
        endcase
        resync_tick();
        return;
      end
      if (idx % 2 == 0) begin
        left = set;
        while (left != '0) begin
          hit = left & 12'($urandom);
          queue_item(hcs_pkg::OpTick, 6'($urandom), hit | (12'($urandom) & ~left), 1'b0,
                     1'b0, 1'b0);
          left = left & ~hit;
        end
      end else begin
        repeat ($urandom_range(0, 3))
          queue_item(hcs_pkg::OpTick, 6'($urandom), 12'($urandom), 1'b0, 1'b0, 1'b0);
        queue_item(hcs_pkg::OpTick, 6'($urandom), 12'($urandom) & ~set, 1'b0, 1'b0, 1'b1);
      end
    end
    if (flawed) resync_tick();
  endtask

  task automatic drain();
    while (queued_items.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(hcs_pkg::reg_e r, logic [5:0] v);
    logic [5:0] kept;
    kept = (r == hcs_pkg::RegLocateCycles) ? (v & 6'd7) : v;
    drain();
    for (int rd = 0; rd < 2; rd++) begin
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= (rd == 0);
      paddr <= hcs_pkg::AddrW'(4 * int'(r));
      pwdata <= hcs_pkg::DataW'(v);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (rd == 0) begin
        case (r)
          hcs_pkg::RegHomingAxes: cfg.homing_axes = v;
          hcs_pkg::RegGang0Motors: cfg.gang0_motors = v;
          hcs_pkg::RegGang1Motors: cfg.gang1_motors = v;
          hcs_pkg::RegSharedEnd: cfg.shared_endstop = v;
          hcs_pkg::RegGang0End: cfg.gang0_endstop = v;
          hcs_pkg::RegGang1End: cfg.gang1_endstop = v;
          hcs_pkg::RegLocateCycles: cfg.locate_cycles = v[2:0];
          default: ;
        endcase
      end else if (prdata !== hcs_pkg::DataW'(kept)) begin
        $error("%s: expected %0h, got %0h", r.name(), kept, prdata);
        errors++;
      end
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_all(logic [5:0] ha, logic [5:0] g0m, logic [5:0] g1m,
                             logic [5:0] sh, logic [5:0] g0e, logic [5:0] g1e,
                             logic [5:0] loc);
    write_reg(hcs_pkg::RegHomingAxes, ha);
    write_reg(hcs_pkg::RegGang0Motors, g0m);
    write_reg(hcs_pkg::RegGang1Motors, g1m);
    write_reg(hcs_pkg::RegSharedEnd, sh);
    write_reg(hcs_pkg::RegGang0End, g0e);
    write_reg(hcs_pkg::RegGang1End, g1e);
    write_reg(hcs_pkg::RegLocateCycles, loc);
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timed out with %0d items queued and %0d results due", queued_items.size(),
           due_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // idle tick with every event set: only the lock state shows
    queue_item(hcs_pkg::OpTick, 6'h3F, 12'hFFF, 1'b1, 1'b1, 1'b1);
    // nothing to move: done at once
    queue_item(hcs_pkg::OpStart, 6'h00, 12'hFFF, 1'b1, 1'b1, 1'b1);
    plan_cycle(6'h3F, 1'b0);
    // lock first, then reset wins over door and stop
    queue_item(hcs_pkg::OpStart, 6'h3F, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'hFFF, 1'b1, 1'b1, 1'b1);
    queue_item(hcs_pkg::OpStart, 6'h02, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h000, 1'b0, 1'b1, 1'b1);
    queue_item(hcs_pkg::OpStart, 6'h01, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h000, 1'b0, 1'b0, 1'b1);
    // second start while busy is dropped; switch still seen at end of pulloff
    queue_item(hcs_pkg::OpStart, 6'h05, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpStart, 6'h3F, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h004, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'hFFF, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h004, 1'b0, 1'b0, 1'b1);
    // lower the locate count mid-cycle so the cycle ends early
    write_reg(hcs_pkg::RegLocateCycles, 6'd3);
    queue_item(hcs_pkg::OpStart, 6'h01, 12'h000, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h001, 1'b0, 1'b0, 1'b0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h000, 1'b0, 1'b0, 1'b1);
    write_reg(hcs_pkg::RegLocateCycles, 6'd0);
    queue_item(hcs_pkg::OpTick, 6'h00, 12'h001, 1'b0, 1'b0, 1'b0);

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: program_all(6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'd0);
        1: program_all(6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'd7);
        2: program_all(6'h3F, 6'h3F, 6'h3F, 6'h00, 6'h3F, 6'h3F, 6'd7);
        3: program_all(6'h3F, 6'h3F, 6'h3F, 6'h00, 6'h3F, 6'h00, 6'd0);
        default: program_all(6'($urandom), 6'($urandom), 6'($urandom),
                             6'($urandom) & 6'($urandom), 6'($urandom) | 6'($urandom),
                             6'($urandom), 6'($urandom_range(0, 7)));
      endcase
      target = queued + PhaseItems;
      while (queued < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            plan_cycle(($urandom_range(0, 3) == 0) ? 6'h3F : 6'($urandom_range(1, 63)), 1'b0);
          6, 7: plan_cycle(6'($urandom_range(1, 63)), 1'b1);
          8: begin
            repeat ($urandom_range(1, 8))
              queue_item(hcs_pkg::op_e'($urandom_range(0, 1)), 6'($urandom), 12'($urandom),
                         ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0),
                         ($urandom_range(0, 3) == 0));
            resync_tick();
          end
          default: queue_item(hcs_pkg::OpStart, 6'h00, 12'($urandom), 1'b0, 1'b0, 1'b0);
        endcase
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d items over %0d register settings: %0d moves, %0d cycles done",
             accepted, RandomPhases + 1, moves_seen, done_seen);
    $display("alarms reset/door/approach/pulloff: %0d/%0d/%0d/%0d",
             alarm_tally[hcs_pkg::AlarmReset], alarm_tally[hcs_pkg::AlarmDoor],
             alarm_tally[hcs_pkg::AlarmApproach], alarm_tally[hcs_pkg::AlarmPulloff]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
